### rtl/bse_pkg.sv
// Shared types, constants and helper functions of the Burning Ship escape-time engine.
`default_nettype none

package bse_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int COORD_W    = 10;
   localparam int COUNT_W    = 16;
   localparam int STEP_W     = 31;
   localparam int WORD_W     = 32;
   localparam int PROD_W     = 64;
   localparam int WIDE_W     = 48;
   localparam int CSR_ADDR_W = 5;

   localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'd1 << (2 * FRAC_BITS + 4);

   typedef enum logic [2:0] {
      REG_X_ORIGIN = 3'd0,
      REG_Y_ORIGIN = 3'd1,
      REG_X_STEP   = 3'd2,
      REG_Y_STEP   = 3'd3,
      REG_MAX_ITER = 3'd4
   } reg_index_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_MUL_CX = 10'b00_0000_0010,
      ST_MUL_CY = 10'b00_0000_0100,
      ST_INIT   = 10'b00_0000_1000,
      ST_UPDATE = 10'b00_0001_0000,
      ST_MUL_AA = 10'b00_0010_0000,
      ST_MUL_BB = 10'b00_0100_0000,
      ST_MUL_AB = 10'b00_1000_0000,
      ST_CHECK  = 10'b01_0000_0000,
      ST_DONE   = 10'b10_0000_0000
   } state_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(signed'(33'sd2147483647));
      lo = -WIDE_W'(signed'(33'sd2147483648));
      if (v > hi) begin
         sat_word = {1'b0, {(WORD_W-1){1'b1}}};
      end else if (v < lo) begin
         sat_word = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         sat_word = v[WORD_W-1:0];
      end
   endfunction

   function automatic logic signed [WIDE_W-1:0] abs_wide(input logic signed [WIDE_W-1:0] v);
      abs_wide = v[WIDE_W-1] ? -v : v;
   endfunction

endpackage

`default_nettype wire

### rtl/burning_ship_escape_time.sv
// Top level of the Burning Ship escape-time engine with its register port and sequencer.
`default_nettype none

// One transaction carries a pixel coordinate and returns its iteration count, an escaped
// flag and the echoed coordinate. All products go through one shared 32 by 32 signed
// multiplier. After a pixel is taken, the point is formed in MUL_CX, MUL_CY and INIT, and
// each round runs through UPDATE, MUL_AA, MUL_BB, MUL_AB and CHECK. When the point does
// not escape, a final limit check in UPDATE ends the rounds, with rounds at most max_iter.
// The result is handed over in DONE, and the next pixel can be taken once the sequencer
// is back in IDLE. The input is stalled while the sequencer is out of IDLE. A finished
// result waits in the output register while the next transaction is taken, and a second
// result waits in the sequencer until that register is free.
module burning_ship_escape_time
   import bse_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_W-1:0]    req_pixel_col,
   input  wire logic [COORD_W-1:0]    req_pixel_row,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COUNT_W-1:0]         rsp_iter_count,
   output logic                       rsp_escaped,
   output logic [COORD_W-1:0]         rsp_out_col,
   output logic [COORD_W-1:0]         rsp_out_row,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [WORD_W-1:0]     pwdata,
   output logic [WORD_W-1:0]          prdata,
   output logic                       pready
);

   state_type                 state_ff, state_in;
   logic signed [WORD_W-1:0]  xorg_ff, xorg_in, yorg_ff, yorg_in;
   logic [STEP_W-1:0]         xstep_ff, xstep_in, ystep_ff, ystep_in;
   logic [COUNT_W-1:0]        maxit_ff, maxit_in;
   logic [COORD_W-1:0]        col_ff, col_in, row_ff, row_in;
   logic signed [WORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [WORD_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic signed [PROD_W-1:0]  p_ff, p_in, aa_ff, aa_in, bb_ff, bb_in, ab_ff, ab_in;
   logic [COUNT_W-1:0]        n_ff, n_in;
   logic                      esc_ff, esc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_esc_ff, rsp_esc_in;
   logic [COORD_W-1:0]        rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;

   logic                      cfg_write;
   logic                      req_take;
   logic                      rsp_free;
   logic signed [WORD_W-1:0]  mul_x, mul_y;
   logic signed [WIDE_W-1:0]  prod_wide, aa_sh, bb_sh, ab_sh, re_sum, im_sum;
   logic [PROD_W-1:0]         mag_sum;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = rsp_count_ff;
   assign rsp_escaped    = rsp_esc_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;

   always_comb begin
      case (paddr[4:2])
         REG_X_ORIGIN: prdata = xorg_ff;
         REG_Y_ORIGIN: prdata = yorg_ff;
         REG_X_STEP:   prdata = {1'b0, xstep_ff};
         REG_Y_STEP:   prdata = {1'b0, ystep_ff};
         REG_MAX_ITER: prdata = {{(WORD_W-COUNT_W){1'b0}}, maxit_ff};
         default:      prdata = '0;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_MUL_CX: begin
            mul_x = {{(WORD_W-COORD_W){1'b0}}, col_ff};
            mul_y = {1'b0, xstep_ff};
         end
         ST_MUL_CY: begin
            mul_x = {{(WORD_W-COORD_W){1'b0}}, row_ff};
            mul_y = {1'b0, ystep_ff};
         end
         ST_MUL_AA: begin
            mul_x = a_ff;
            mul_y = a_ff;
         end
         ST_MUL_BB: begin
            mul_x = b_ff;
            mul_y = b_ff;
         end
         ST_MUL_AB: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign p_in      = mul_x * mul_y;
   assign prod_wide = p_ff[WIDE_W-1:0];
   assign aa_sh     = WIDE_W'(aa_ff[PROD_W-1:FRAC_BITS]);
   assign bb_sh     = WIDE_W'(bb_ff[PROD_W-1:FRAC_BITS]);
   assign ab_sh     = WIDE_W'(signed'(ab_ff[PROD_W-1:FRAC_BITS-1]));
   assign re_sum    = abs_wide(aa_sh - bb_sh + WIDE_W'(cx_ff));
   assign im_sum    = abs_wide(ab_sh) + WIDE_W'(cy_ff);
   assign mag_sum   = {1'b0, aa_ff[PROD_W-2:0]} + {1'b0, bb_ff[PROD_W-2:0]};

   always_comb begin
      xorg_in  = xorg_ff;
      yorg_in  = yorg_ff;
      xstep_in = xstep_ff;
      ystep_in = ystep_ff;
      maxit_in = maxit_ff;
      if (cfg_write) begin
         case (paddr[4:2])
            REG_X_ORIGIN: xorg_in  = pwdata;
            REG_Y_ORIGIN: yorg_in  = pwdata;
            REG_X_STEP:   xstep_in = pwdata[STEP_W-1:0];
            REG_Y_STEP:   ystep_in = pwdata[STEP_W-1:0];
            REG_MAX_ITER: maxit_in = pwdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      ab_in        = ab_ff;
      n_in         = n_ff;
      esc_in       = esc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               col_in   = req_pixel_col;
               row_in   = req_pixel_row;
               state_in = ST_MUL_CX;
            end
         end
         ST_MUL_CX: begin
            state_in = ST_MUL_CY;
         end
         ST_MUL_CY: begin
            cx_in    = sat_word(WIDE_W'(xorg_ff) + prod_wide);
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cy_in    = sat_word(WIDE_W'(yorg_ff) + prod_wide);
            aa_in    = '0;
            bb_in    = '0;
            ab_in    = '0;
            n_in     = '0;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (n_ff >= maxit_ff) begin
               esc_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               a_in     = sat_word(re_sum);
               b_in     = sat_word(im_sum);
               state_in = ST_MUL_AA;
            end
         end
         ST_MUL_AA: begin
            state_in = ST_MUL_BB;
         end
         ST_MUL_BB: begin
            aa_in    = p_ff;
            state_in = ST_MUL_AB;
         end
         ST_MUL_AB: begin
            bb_in    = p_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ab_in = p_ff;
            if (mag_sum > ESCAPE_LIMIT) begin
               esc_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = n_ff;
               rsp_esc_in   = esc_ff;
               rsp_col_in   = col_ff;
               rsp_row_in   = row_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         xorg_ff      <= -32'sd33554432;
         yorg_ff      <= -32'sd33554432;
         xstep_ff     <= 31'd65536;
         ystep_ff     <= 31'd65536;
         maxit_ff     <= 16'd256;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         xorg_ff      <= xorg_in;
         yorg_ff      <= yorg_in;
         xstep_ff     <= xstep_in;
         ystep_ff     <= ystep_in;
         maxit_ff     <= maxit_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      p_ff         <= p_in;
      aa_ff        <= aa_in;
      bb_ff        <= bb_in;
      ab_ff        <= ab_in;
      n_ff         <= n_in;
      esc_ff       <= esc_in;
      rsp_count_ff <= rsp_count_in;
      rsp_esc_ff   <= rsp_esc_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

endmodule

`default_nettype wire
